[sv/aur_pkg.sv]
// Shared types, codes and constants of the H.264 access unit repacker.
// No dependencies; every other file of the block but aur_param_store imports this package.
`default_nettype none
package aur_pkg;

    // NAL unit header bytes seen in the stream.
    localparam logic [7:0] NAL_SPS   = 8'h67;
    localparam logic [7:0] NAL_PPS   = 8'h68;
    localparam logic [7:0] NAL_IDR   = 8'h65;
    localparam logic [7:0] NAL_P     = 8'h41;
    localparam logic [7:0] NAL_P_REF = 8'h61;

    // Status codes carried with every output transaction.
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_NOT_KEY = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;
    localparam logic [1:0] ST_FAULT   = 2'd3;

    localparam int SPS_LEN_W = 6;
    localparam int PPS_LEN_W = 4;
    localparam int AUD_LEN   = 6;
    localparam int HEAD_LEN  = 5;

    typedef enum logic [4:0] {
        PH_HEAD     = 5'b00001,
        PH_PASS_P   = 5'b00010,
        PH_PASS_KEY = 5'b00100,
        PH_KEY_HDR  = 5'b01000,
        PH_DROP     = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        TGT_NONE = 3'b001,
        TGT_SPS  = 3'b010,
        TGT_PPS  = 3'b100
    } target_t;

    typedef enum logic [4:0] {
        CMD_NONE   = 5'b00001,
        CMD_DATA   = 5'b00010,
        CMD_STATUS = 5'b00100,
        CMD_P      = 5'b01000,
        CMD_KEY    = 5'b10000
    } cmd_kind_t;

    typedef enum logic [6:0] {
        E_IDLE   = 7'b0000001,
        E_AUD    = 7'b0000010,
        E_PWIN   = 7'b0000100,
        E_SC     = 7'b0001000,
        E_SPS    = 7'b0010000,
        E_PPS    = 7'b0100000,
        E_ISLICE = 7'b1000000
    } emit_state_t;

    // What the parser asks of the output side for one accepted byte.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
        logic       key;
        logic [1:0] status;
    } cmd_t;

    // Stable parser state that the output side reads during a burst.
    typedef struct packed {
        logic [SPS_LEN_W-1:0] sps_count;
        logic [PPS_LEN_W-1:0] pps_count;
        logic [4:0][7:0]      window;
    } burst_info_t;

    // Access unit delimiter: start code, type 9, primary_pic_type all.
    function automatic logic [7:0] aud_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd3:    r = 8'h01;
            3'd4:    r = 8'h09;
            3'd5:    r = 8'hF0;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/aur_param_store.sv]
// SPS and PPS body memories: one write port and one registered read port each.
// Depends on nothing but its parameters.
`default_nettype none
module aur_param_store #(
    parameter int SPS_DEPTH = 32,
    parameter int PPS_DEPTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         sps_we,
    input  wire logic [$clog2(SPS_DEPTH)-1:0] sps_waddr,
    input  wire logic [$clog2(SPS_DEPTH)-1:0] sps_raddr,
    input  wire logic                         pps_we,
    input  wire logic [$clog2(PPS_DEPTH)-1:0] pps_waddr,
    input  wire logic [$clog2(PPS_DEPTH)-1:0] pps_raddr,
    input  wire logic [7:0]                   wdata,
    output logic      [7:0]                   sps_rdata,
    output logic      [7:0]                   pps_rdata
);
    logic [7:0] sps_mem [SPS_DEPTH];
    logic [7:0] pps_mem [PPS_DEPTH];

    always_ff @(posedge clk)
    begin
        if (sps_we)
        begin
            sps_mem[sps_waddr] <= wdata;
        end
        sps_rdata <= sps_mem[sps_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pps_we)
        begin
            pps_mem[pps_waddr] <= wdata;
        end
        pps_rdata <= pps_mem[pps_raddr];
    end
endmodule
`default_nettype wire

[sv/aur_frame_ctl.sv]
// Frame parser: classifies frames, tracks NAL boundaries and captures SPS/PPS.
// Depends on aur_pkg; drives the write ports of aur_param_store.
`default_nettype none
module aur_frame_ctl #(
    parameter int SPS_DEPTH = 32,
    parameter int PPS_DEPTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         frame_last,
    output aur_pkg::cmd_t                     cmd,
    output aur_pkg::burst_info_t              info,
    output logic                              sps_we,
    output logic      [$clog2(SPS_DEPTH)-1:0] sps_waddr,
    output logic                              pps_we,
    output logic      [$clog2(PPS_DEPTH)-1:0] pps_waddr,
    output logic      [7:0]                   wdata
);
    import aur_pkg::*;

    localparam int SAW = $clog2(SPS_DEPTH);
    localparam int PAW = $clog2(PPS_DEPTH);
    localparam logic [SPS_LEN_W-1:0] SPS_D   = SPS_LEN_W'(SPS_DEPTH);
    localparam logic [SPS_LEN_W-1:0] SPS_LIM = SPS_LEN_W'(SPS_DEPTH + 4);
    localparam logic [SPS_LEN_W-1:0] SPS_SAT = {SPS_LEN_W{1'b1}};
    localparam logic [PPS_LEN_W-1:0] PPS_D   = PPS_LEN_W'(PPS_DEPTH);
    localparam logic [PPS_LEN_W-1:0] PPS_LIM = PPS_LEN_W'(PPS_DEPTH + 4);
    localparam logic [PPS_LEN_W-1:0] PPS_SAT = {PPS_LEN_W{1'b1}};

    phase_t               phase_reg, phase_next;
    target_t              tgt_reg, tgt_next;
    logic [2:0]           hcnt_reg, hcnt_next, hc;
    logic                 key_seen_reg, key_seen_next;
    logic                 pv_reg, pv_next;
    logic [SPS_LEN_W-1:0] sl_reg, sl_next;
    logic [PPS_LEN_W-1:0] pl_reg, pl_next;
    logic [4:0][7:0]      win_reg, win_next, nwin;
    logic                 sc, fault, do_app;
    logic [1:0]           reject_st;

    always_comb
    begin
        phase_next    = phase_reg;
        tgt_next      = tgt_reg;
        hcnt_next     = hcnt_reg;
        key_seen_next = key_seen_reg;
        pv_next       = pv_reg;
        sl_next       = sl_reg;
        pl_next       = pl_reg;
        win_next      = win_reg;
        cmd           = '{kind: CMD_NONE, data: 8'h00, last: 1'b0, key: 1'b0, status: ST_DATA};
        fault         = 1'b0;
        do_app        = 1'b0;
        sps_we        = 1'b0;
        pps_we        = 1'b0;
        sps_waddr     = '0;
        pps_waddr     = '0;
        wdata         = data_byte;
        hc            = hcnt_reg + 3'd1;
        nwin          = {data_byte, win_reg[4:1]};
        sc            = (nwin[0] == 8'h00) && (nwin[1] == 8'h00) && (nwin[2] == 8'h00)
                        && (nwin[3] == 8'h01);
        reject_st     = key_seen_reg ? ST_UNSUP : ST_NOT_KEY;

        if (accept)
        begin
            win_next = nwin;
            case (phase_reg)
                PH_HEAD:
                begin
                    if (hc < 3'(HEAD_LEN))
                    begin
                        hcnt_next = hc;
                        if (frame_last)
                        begin
                            hcnt_next = 3'd0;
                            cmd = '{kind: CMD_STATUS, data: 8'h00, last: 1'b1, key: 1'b0,
                                    status: reject_st};
                        end
                    end
                    else
                    begin
                        hcnt_next = 3'd0;
                        if (sc && data_byte == NAL_SPS)
                        begin
                            key_seen_next = 1'b1;
                            if (!pv_reg)
                            begin
                                tgt_next  = TGT_SPS;
                                sps_we    = 1'b1;
                                sps_waddr = '0;
                                sl_next   = SPS_LEN_W'(1);
                                pl_next   = '0;
                            end
                            else
                            begin
                                tgt_next = TGT_NONE;
                            end
                            if (frame_last)
                            begin
                                fault = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_KEY_HDR;
                            end
                        end
                        else if (key_seen_reg && sc
                                 && (data_byte == NAL_P || data_byte == NAL_P_REF))
                        begin
                            cmd = '{kind: CMD_P, data: 8'h00, last: frame_last, key: 1'b0,
                                    status: ST_DATA};
                            phase_next = frame_last ? PH_HEAD : PH_PASS_P;
                        end
                        else
                        begin
                            cmd = '{kind: CMD_STATUS, data: 8'h00, last: 1'b1, key: 1'b0,
                                    status: reject_st};
                            phase_next = frame_last ? PH_HEAD : PH_DROP;
                        end
                    end
                end
                PH_PASS_P, PH_PASS_KEY:
                begin
                    cmd = '{kind: CMD_DATA, data: data_byte, last: frame_last,
                            key: (phase_reg == PH_PASS_KEY), status: ST_DATA};
                    if (frame_last)
                    begin
                        phase_next = PH_HEAD;
                    end
                end
                PH_KEY_HDR:
                begin
                    if (sc)
                    begin
                        // The start code that ended the unit was captured; take it back.
                        if (!pv_reg)
                        begin
                            if (tgt_reg == TGT_SPS)
                            begin
                                sl_next = (sl_reg >= SPS_LEN_W'(4)) ? sl_reg - SPS_LEN_W'(4) : '0;
                            end
                            else if (tgt_reg == TGT_PPS)
                            begin
                                pl_next = (pl_reg >= PPS_LEN_W'(4)) ? pl_reg - PPS_LEN_W'(4) : '0;
                            end
                        end
                        if (data_byte == NAL_IDR)
                        begin
                            if (!pv_reg && pl_next == '0)
                            begin
                                fault = 1'b1;
                            end
                            else
                            begin
                                pv_next    = 1'b1;
                                tgt_next   = TGT_NONE;
                                cmd = '{kind: CMD_KEY, data: 8'h00, last: frame_last, key: 1'b1,
                                        status: ST_DATA};
                                phase_next = frame_last ? PH_HEAD : PH_PASS_KEY;
                            end
                        end
                        else if (!pv_reg)
                        begin
                            do_app = 1'b1;
                            if (data_byte == NAL_SPS)
                            begin
                                tgt_next = TGT_SPS;
                                sl_next  = '0;
                            end
                            else if (data_byte == NAL_PPS)
                            begin
                                tgt_next = TGT_PPS;
                                pl_next  = '0;
                            end
                            else
                            begin
                                tgt_next = TGT_NONE;
                            end
                        end
                    end
                    else if (!pv_reg)
                    begin
                        do_app = 1'b1;
                    end

                    if (do_app)
                    begin
                        if (tgt_next == TGT_SPS)
                        begin
                            if (sl_next < SPS_D)
                            begin
                                sps_we    = 1'b1;
                                sps_waddr = sl_next[SAW-1:0];
                            end
                            if (sl_next != SPS_SAT)
                            begin
                                sl_next = sl_next + SPS_LEN_W'(1);
                            end
                            if (sl_next > SPS_LIM)
                            begin
                                fault = 1'b1;
                            end
                        end
                        else if (tgt_next == TGT_PPS)
                        begin
                            if (pl_next < PPS_D)
                            begin
                                pps_we    = 1'b1;
                                pps_waddr = pl_next[PAW-1:0];
                            end
                            if (pl_next != PPS_SAT)
                            begin
                                pl_next = pl_next + PPS_LEN_W'(1);
                            end
                            if (pl_next > PPS_LIM)
                            begin
                                fault = 1'b1;
                            end
                        end
                    end

                    if (!fault && phase_next == PH_KEY_HDR && frame_last)
                    begin
                        fault = 1'b1;
                    end
                end
                default:
                begin
                    if (frame_last)
                    begin
                        phase_next = PH_HEAD;
                    end
                end
            endcase

            if (fault)
            begin
                tgt_next   = TGT_NONE;
                cmd = '{kind: CMD_STATUS, data: 8'h00, last: 1'b1, key: 1'b1, status: ST_FAULT};
                phase_next = frame_last ? PH_HEAD : PH_DROP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            tgt_reg      <= TGT_NONE;
            hcnt_reg     <= 3'd0;
            key_seen_reg <= 1'b0;
            pv_reg       <= 1'b0;
            sl_reg       <= '0;
            pl_reg       <= '0;
            win_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tgt_reg      <= tgt_next;
            hcnt_reg     <= hcnt_next;
            key_seen_reg <= key_seen_next;
            pv_reg       <= pv_next;
            sl_reg       <= sl_next;
            pl_reg       <= pl_next;
            win_reg      <= win_next;
        end
    end

    assign info.sps_count = (sl_reg > SPS_D) ? SPS_D : sl_reg;
    assign info.pps_count = (pl_reg > PPS_D) ? PPS_D : pl_reg;
    assign info.window    = win_reg;
endmodule
`default_nettype wire

[sv/aur_emitter.sv]
// Output sequencer: plays out pass-through bytes, status items and header bursts.
// Depends on aur_pkg; reads the stores of aur_param_store.
`default_nettype none
module aur_emitter #(
    parameter int SPS_DEPTH = 32,
    parameter int PPS_DEPTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire aur_pkg::cmd_t                cmd,
    input  wire aur_pkg::burst_info_t         info,
    input  wire logic [7:0]                   sps_rdata,
    input  wire logic [7:0]                   pps_rdata,
    output logic      [$clog2(SPS_DEPTH)-1:0] sps_raddr,
    output logic      [$clog2(PPS_DEPTH)-1:0] pps_raddr,
    output logic                              in_ready,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [7:0]                   m_byte,
    output logic                              m_last,
    output logic                              m_key,
    output logic      [1:0]                   m_status
);
    import aur_pkg::*;

    localparam int SAW = $clog2(SPS_DEPTH);
    localparam int PAW = $clog2(PPS_DEPTH);

    emit_state_t    st_reg, st_next, after_reg, after_next;
    logic [5:0]     cnt_reg, cnt_next, cnt_inc;
    logic           keym_reg, keym_next, plast_reg, plast_next;
    logic           ov_reg, ov_next, olast_reg, olast_next, okey_reg, okey_next;
    logic [7:0]     obyte_reg, obyte_next;
    logic [1:0]     ost_reg, ost_next;
    logic           slot, sps_end, pps_end;

    assign slot     = !ov_reg || m_ready;
    assign in_ready = (st_reg == E_IDLE) && slot;
    assign cnt_inc  = cnt_reg + 6'd1;
    assign sps_end  = (cnt_inc == info.sps_count);
    assign pps_end  = (cnt_inc == 6'(info.pps_count));

    // Keep the store read one entry ahead of the byte being shown.
    always_comb
    begin
        sps_raddr = '0;
        pps_raddr = '0;
        if (st_reg == E_SPS)
        begin
            sps_raddr = (slot && !sps_end) ? cnt_inc[SAW-1:0] : cnt_reg[SAW-1:0];
        end
        if (st_reg == E_PPS)
        begin
            pps_raddr = (slot && !pps_end) ? cnt_inc[PAW-1:0] : cnt_reg[PAW-1:0];
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        after_next = after_reg;
        cnt_next   = cnt_reg;
        keym_next  = keym_reg;
        plast_next = plast_reg;
        ov_next    = ov_reg && !m_ready;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        okey_next  = okey_reg;
        ost_next   = ost_reg;

        case (st_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        CMD_DATA, CMD_STATUS:
                        begin
                            ov_next    = 1'b1;
                            obyte_next = cmd.data;
                            olast_next = cmd.last;
                            okey_next  = cmd.key;
                            ost_next   = cmd.status;
                        end
                        CMD_P, CMD_KEY:
                        begin
                            ov_next    = 1'b1;
                            obyte_next = aud_byte(3'd0);
                            olast_next = 1'b0;
                            okey_next  = cmd.key;
                            ost_next   = ST_DATA;
                            keym_next  = cmd.key;
                            plast_next = cmd.last;
                            cnt_next   = 6'd1;
                            st_next    = E_AUD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            E_AUD:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = aud_byte(cnt_reg[2:0]);
                    olast_next = 1'b0;
                    okey_next  = keym_reg;
                    ost_next   = ST_DATA;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == 6'(AUD_LEN))
                    begin
                        cnt_next   = 6'd0;
                        st_next    = keym_reg ? E_SC : E_PWIN;
                        after_next = E_SPS;
                    end
                end
            end
            E_PWIN:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = info.window[cnt_reg[2:0]];
                    olast_next = (cnt_inc == 6'(HEAD_LEN)) ? plast_reg : 1'b0;
                    okey_next  = 1'b0;
                    ost_next   = ST_DATA;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == 6'(HEAD_LEN))
                    begin
                        st_next = E_IDLE;
                    end
                end
            end
            E_SC:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = (cnt_reg == 6'd3) ? 8'h01 : 8'h00;
                    olast_next = 1'b0;
                    okey_next  = 1'b1;
                    ost_next   = ST_DATA;
                    cnt_next   = cnt_inc;
                    if (cnt_reg == 6'd3)
                    begin
                        cnt_next = 6'd0;
                        case (after_reg)
                            E_SPS:
                            begin
                                if (info.sps_count != '0)
                                begin
                                    st_next = E_SPS;
                                end
                                after_next = E_PPS;
                            end
                            E_PPS:
                            begin
                                if (info.pps_count != '0)
                                begin
                                    st_next = E_PPS;
                                end
                                after_next = E_ISLICE;
                            end
                            default:
                            begin
                                st_next = E_ISLICE;
                            end
                        endcase
                    end
                end
            end
            E_SPS:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = sps_rdata;
                    olast_next = 1'b0;
                    okey_next  = 1'b1;
                    ost_next   = ST_DATA;
                    cnt_next   = cnt_inc;
                    if (sps_end)
                    begin
                        cnt_next = 6'd0;
                        st_next  = E_SC;
                    end
                end
            end
            E_PPS:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = pps_rdata;
                    olast_next = 1'b0;
                    okey_next  = 1'b1;
                    ost_next   = ST_DATA;
                    cnt_next   = cnt_inc;
                    if (pps_end)
                    begin
                        cnt_next = 6'd0;
                        st_next  = E_SC;
                    end
                end
            end
            E_ISLICE:
            begin
                if (slot)
                begin
                    ov_next    = 1'b1;
                    obyte_next = NAL_IDR;
                    olast_next = plast_reg;
                    okey_next  = 1'b1;
                    ost_next   = ST_DATA;
                    st_next    = E_IDLE;
                end
            end
            default:
            begin
                st_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= E_IDLE;
            after_reg <= E_SPS;
            cnt_reg   <= 6'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            after_reg <= after_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keym_reg  <= keym_next;
        plast_reg <= plast_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        okey_reg  <= okey_next;
        ost_reg   <= ost_next;
    end

    assign m_valid  = ov_reg;
    assign m_byte   = obyte_reg;
    assign m_last   = olast_reg;
    assign m_key    = okey_reg;
    assign m_status = ost_reg;
endmodule
`default_nettype wire

[sv/h264_access_unit_repacker.sv]
// Top level of the H.264 access unit repacker: parser, parameter store, sequencer.
// Depends on aur_pkg, aur_frame_ctl, aur_param_store and aur_emitter.
//
// The block takes an Annex B stream one byte per transaction, with tlast on the last
// byte of each frame, and writes each frame out as a clean access unit. A frame that
// opens 00 00 00 01 67 is a key frame: its SPS, PPS, SEI and other leading units are
// dropped and replaced by an AUD, the stored SPS and PPS (each behind a start code)
// and the I slice from its start code to the end of the frame. The SPS and PPS bodies
// are captured from key frames until one capture succeeds and are kept from then on.
// A frame that opens 00 00 00 01 41 or 61 is a P frame and comes out behind an AUD,
// unchanged. Anything else yields one status transaction (tdata zero, tlast high):
// status 1 before the first key frame, 2 for an unsupported or short frame, 3 for a
// header fault (parameter set larger than its store, missing PPS or missing I slice);
// the rest of that frame is then swallowed. Rate: one input byte per cycle while bytes
// pass straight through or are dropped and the output does not stall. The fifth byte
// of a P frame holds the input while the AUD and the five header bytes go out, and the
// I slice header of a key frame holds it while the AUD, three start codes, the stored
// SPS and PPS and the I slice NAL byte go out; the sequencer feeds the single output
// register one byte per cycle while it is free, with the stores read one entry ahead.
// The stores need no clearing after reset, so the block is ready at once.
`default_nettype none
module h264_access_unit_repacker #(
    parameter int SPS_DEPTH = 32,
    parameter int PPS_DEPTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // frame_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // out_last
    output logic      [2:0] m_axis_tuser    // [0] key_frame, [2:1] status
);
    import aur_pkg::*;

    localparam int SAW = $clog2(SPS_DEPTH);
    localparam int PAW = $clog2(PPS_DEPTH);

    logic            accept;
    cmd_t            cmd;
    burst_info_t     info;
    logic            sps_we, pps_we;
    logic [SAW-1:0]  sps_waddr, sps_raddr;
    logic [PAW-1:0]  pps_waddr, pps_raddr;
    logic [7:0]      wdata, sps_rdata, pps_rdata;
    logic            m_key;
    logic [1:0]      m_status;

    // A transaction on the input side is taken only while the sequencer is idle.
    assign accept = s_axis_tvalid && s_axis_tready;

    aur_frame_ctl #(
        .SPS_DEPTH (SPS_DEPTH),
        .PPS_DEPTH (PPS_DEPTH)
    ) u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .frame_last (s_axis_tlast),
        .cmd        (cmd),
        .info       (info),
        .sps_we     (sps_we),
        .sps_waddr  (sps_waddr),
        .pps_we     (pps_we),
        .pps_waddr  (pps_waddr),
        .wdata      (wdata)
    );

    aur_param_store #(
        .SPS_DEPTH (SPS_DEPTH),
        .PPS_DEPTH (PPS_DEPTH)
    ) u_store (
        .clk       (clk),
        .sps_we    (sps_we),
        .sps_waddr (sps_waddr),
        .sps_raddr (sps_raddr),
        .pps_we    (pps_we),
        .pps_waddr (pps_waddr),
        .pps_raddr (pps_raddr),
        .wdata     (wdata),
        .sps_rdata (sps_rdata),
        .pps_rdata (pps_rdata)
    );

    // Writes only happen on accepted bytes and reads only during bursts, when no
    // byte is accepted, so the two never touch the same entry in one cycle.
    aur_emitter #(
        .SPS_DEPTH (SPS_DEPTH),
        .PPS_DEPTH (PPS_DEPTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .info      (info),
        .sps_rdata (sps_rdata),
        .pps_rdata (pps_rdata),
        .sps_raddr (sps_raddr),
        .pps_raddr (pps_raddr),
        .in_ready  (s_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_byte    (m_axis_tdata),
        .m_last    (m_axis_tlast),
        .m_key     (m_key),
        .m_status  (m_status)
    );

    assign m_axis_tuser = {m_status, m_key};
endmodule
`default_nettype wire

[sv/aur_checker.sv]
// Port-level checks of the H.264 access unit repacker, bound to its top level.
// Depends on aur_pkg for the status codes.
`default_nettype none
module aur_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [2:0] m_axis_tuser
);
    import aur_pkg::*;

    // A stalled output transaction keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

    // Input is taken only when the output register has room for a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input ready while output register is full");

    // A status transaction is a lone zero byte that closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_DATA |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("status transaction with data or without last");

    // Header faults belong to key frames; the other rejections never do.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] == ST_NOT_KEY || m_axis_tuser[2:1] == ST_UNSUP)
        |-> !m_axis_tuser[0])
    else $error("rejected frame flagged as key frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == ST_FAULT |-> m_axis_tuser[0])
    else $error("header fault not flagged as key frame");
endmodule

bind h264_access_unit_repacker aur_checker u_aur_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
